/* rtl/core/mbrc_pkg.sv */
// ----------------------------------------------------------------------------
// mbrc_pkg
// shared types, constants and the byte-wide crc-16 update for the request check
// ----------------------------------------------------------------------------
`default_nettype none

package mbrc_pkg;

  localparam int unsigned PosW = 3;

  // positions of the bytes within a request frame
  localparam logic [PosW-1:0] POS_UNIT      = 3'd0;
  localparam logic [PosW-1:0] POS_FUNCTION  = 3'd1;
  localparam logic [PosW-1:0] POS_ADDR_HI   = 3'd2;
  localparam logic [PosW-1:0] POS_ADDR_LO   = 3'd3;
  localparam logic [PosW-1:0] POS_QTY_HI    = 3'd4;
  localparam logic [PosW-1:0] POS_QTY_LO    = 3'd5;
  localparam logic [PosW-1:0] POS_CRC_LO    = 3'd6;
  localparam logic [PosW-1:0] POS_CRC_HI    = 3'd7;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_READ_INPUTS  = 8'h02;
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;

  localparam logic [15:0] QTY_MAX_INPUTS  = 16'd2040;
  localparam logic [15:0] QTY_MAX_HOLDING = 16'd127;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_FUNCTION = 2'd1,
    STATUS_BAD_VALUE    = 2'd2,
    STATUS_NO_DEVICE    = 2'd3
  } status_e;

  // reflected crc-16, one byte, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/modbus_rtu_request_check.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_request_check
// checks 8-byte modbus rtu read requests and gives one verdict per frame
// ----------------------------------------------------------------------------
// usage:
//   data channel (data_valid_i / data_stall_o) takes one request byte per item,
//   frames are back to back with no gap, byte 0 is the unit id.
//   result channel (result_valid_o / result_stall_i) gives one item after the
//   eighth byte: status, unit id, function code, start address and quantity.
//   cfg channel (cfg_valid_i / cfg_ready_o) writes device_count, always ready;
//   write it only while no frame is in flight.
//   a byte is taken every cycle while data_stall_o is low; each byte passes an
//   input register and from there is folded into the crc and header registers,
//   and the verdict is registered in the result register as the last byte is folded in.
//   the crc update is a byte-wide unrolled step and sets the cycle time.
//   reset puts the frame position to byte 0, the crc to 0xffff, device_count
//   to 0 and empties both registers.
//   while a result waits under result_stall_i, the input register holds its
//   byte and data_stall_o is raised; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_request_check
  import mbrc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  device_count_i,
  input  wire logic        data_valid_i,
  output logic             data_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             result_valid_o,
  input  wire logic        result_stall_i,
  output logic [1:0]       status_o,
  output logic [7:0]       unit_id_o,
  output logic [7:0]       function_code_o,
  output logic [15:0]      start_address_o,
  output logic [15:0]      quantity_o
);

  logic [7:0]      dev_count_q;
  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic [PosW-1:0] pos_q;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      unit_q, func_q, crc_lo_q;
  logic [15:0]     addr_q, qty_q;
  logic            out_valid_q;
  status_e         status_q, status_d;
  logic [7:0]      out_unit_q, out_func_q;
  logic [15:0]     out_addr_q, out_qty_q;
  logic            out_free, in_go, in_take, frame_end;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !result_stall_i;
  assign in_go       = in_valid_q && out_free;
  assign data_stall_o = in_valid_q && !out_free;
  assign in_take     = data_valid_i && !data_stall_o;
  assign frame_end   = in_go && (pos_q == POS_CRC_HI);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_count_q <= 8'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dev_count_q <= device_count_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (in_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= data_byte_i;
    end
  end

  // crc and position
  always_comb begin
    crc_d = crc_q;
    if (pos_q <= POS_QTY_LO) begin
      crc_d = crc16_byte(crc_q, in_byte_q);
    end else if (pos_q == POS_CRC_HI) begin
      crc_d = CRC_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_UNIT;
      crc_q <= CRC_INIT;
    end else if (in_go) begin
      pos_q <= pos_q + 3'd1;
      crc_q <= crc_d;
    end
  end

  // header capture
  always_ff @(posedge clk_i) begin
    if (in_go) begin
      case (pos_q)
        POS_UNIT:     unit_q        <= in_byte_q;
        POS_FUNCTION: func_q        <= in_byte_q;
        POS_ADDR_HI:  addr_q[15:8]  <= in_byte_q;
        POS_ADDR_LO:  addr_q[7:0]   <= in_byte_q;
        POS_QTY_HI:   qty_q[15:8]   <= in_byte_q;
        POS_QTY_LO:   qty_q[7:0]    <= in_byte_q;
        POS_CRC_LO:   crc_lo_q      <= in_byte_q;
        default:      ;
      endcase
    end
  end

  // verdict, first failing check wins
  always_comb begin
    if (unit_q == 8'd0 || unit_q > dev_count_q) begin
      status_d = STATUS_NO_DEVICE;
    end else if (func_q != FC_READ_INPUTS && func_q != FC_READ_HOLDING) begin
      status_d = STATUS_BAD_FUNCTION;
    end else if (func_q == FC_READ_INPUTS && qty_q > QTY_MAX_INPUTS) begin
      status_d = STATUS_BAD_VALUE;
    end else if (func_q == FC_READ_HOLDING && qty_q > QTY_MAX_HOLDING) begin
      status_d = STATUS_BAD_VALUE;
    end else if (crc_lo_q != crc_q[7:0] || in_byte_q != crc_q[15:8]) begin
      status_d = STATUS_BAD_VALUE;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (frame_end) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !result_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      status_q   <= status_d;
      out_unit_q <= unit_q;
      out_func_q <= func_q;
      out_addr_q <= addr_q;
      out_qty_q  <= qty_q;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign status_o        = status_q;
  assign unit_id_o       = out_unit_q;
  assign function_code_o = out_func_q;
  assign start_address_o = out_addr_q;
  assign quantity_o      = out_qty_q;

`ifndef SYNTHESIS
  a_crc_init_at_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == POS_UNIT) |-> (crc_q == CRC_INIT))
    else $error("crc not at initial value at start of frame");

  a_frame_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> out_valid_q)
    else $error("end of frame gave no result");

  a_blocked_byte_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_free) |=> (in_valid_q && $stable(in_byte_q) && $stable(pos_q)))
    else $error("input register lost a byte while the result was stalled");

  a_ok_needs_valid_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == STATUS_OK) |->
      ((out_func_q == FC_READ_INPUTS || out_func_q == FC_READ_HOLDING)
       && out_unit_q != 8'd0))
    else $error("ok verdict on an illegal header");
`endif

endmodule

`default_nettype wire
